FILE: hdl/gcl_pkg.sv
`timescale 1ns / 1ps
// package for the gcd / lcm unit: operand width, derived widths and sequencer states
// no dependencies

package gcl_pkg;

  localparam int OPERAND_BITS = 16;
  localparam int PRODUCT_BITS = 2 * OPERAND_BITS;
  localparam int ALU_BITS     = PRODUCT_BITS + 1;
  localparam int SHIFT_BITS   = $clog2(OPERAND_BITS);

  typedef logic [OPERAND_BITS-1:0] operand_t;
  typedef logic [PRODUCT_BITS-1:0] product_t;
  typedef logic [ALU_BITS-1:0]     alu_word_t;
  typedef logic [SHIFT_BITS-1:0]   shift_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_MUL,
    ST_FINISH
  } state_t;

endpackage

FILE: hdl/gcl_req_if.sv
`timescale 1ns / 1ps
// request channel of the gcd / lcm unit: valid, ready and the two operands
// depends on gcl_pkg

interface gcl_req_if
  import gcl_pkg::*;
();
  logic     valid;
  logic     ready;
  operand_t first_value;
  operand_t second_value;

  modport source (output valid, output first_value, output second_value, input ready);
  modport sink   (input valid, input first_value, input second_value, output ready);
endinterface

FILE: hdl/gcl_rsp_if.sv
`timescale 1ns / 1ps
// response channel of the gcd / lcm unit: valid, ready, divisor, multiple and error flag
// depends on gcl_pkg

interface gcl_rsp_if
  import gcl_pkg::*;
();
  logic     valid;
  logic     ready;
  operand_t divisor;
  product_t multiple;
  logic     bad_input;

  modport source (output valid, output divisor, output multiple, output bad_input,
                  input ready);
  modport sink   (input valid, input divisor, input multiple, input bad_input,
                  output ready);
endinterface

FILE: hdl/gcd_lcm_unit_top.sv
`timescale 1ns / 1ps
// channel    dir   payload                                handshake
// req        in    first_value[16], second_value[16]      valid / ready
// rsp        out   divisor[16], multiple[32], bad_input   valid / ready
//
// one transaction at a time through a single shared add/subtract unit:
// binary gcd (shift, swap or subtract-and-halve per cycle), then OPERAND_BITS
// restoring divide steps for first/gcd and OPERAND_BITS shift-add steps for
// the product with second, then the hand-over to the response register; a zero
// operand goes from idle straight to the hand-over.
// req.ready is high only while the sequencer is idle; a held response does not
// block the next request, only the hand-over of its result.
// rst is synchronous and clears the sequencer and response valid.
// depends on gcl_pkg, gcl_req_if, gcl_rsp_if

module gcd_lcm_unit_top
  import gcl_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  gcl_req_if.sink       req,
  gcl_rsp_if.source     rsp
);

  state_t    state, state_next;
  operand_t  x, x_next;
  operand_t  y, y_next;
  shift_t    k, k_next;
  shift_t    cnt, cnt_next;
  operand_t  a_hold, a_hold_next;
  operand_t  b_hold, b_hold_next;
  operand_t  g, g_next;
  operand_t  rem, rem_next;
  operand_t  q, q_next;
  product_t  acc, acc_next;
  logic      bad, bad_next;

  logic      rsp_valid, rsp_valid_next;
  operand_t  rsp_div, rsp_div_next;
  product_t  rsp_mul, rsp_mul_next;
  logic      rsp_bad, rsp_bad_next;

  // shared add/subtract unit
  alu_word_t alu_a, alu_b, alu_res;
  logic      alu_sub;
  logic      borrow;

  assign alu_res = alu_a + (alu_b ^ {ALU_BITS{alu_sub}}) + alu_word_t'(alu_sub);
  assign borrow  = alu_res[ALU_BITS-1];

  assign req.ready     = (state == ST_IDLE);
  assign rsp.valid     = rsp_valid;
  assign rsp.divisor   = rsp_div;
  assign rsp.multiple  = rsp_mul;
  assign rsp.bad_input = rsp_bad;

  always_comb begin
    state_next     = state;
    x_next         = x;
    y_next         = y;
    k_next         = k;
    cnt_next       = cnt;
    a_hold_next    = a_hold;
    b_hold_next    = b_hold;
    g_next         = g;
    rem_next       = rem;
    q_next         = q;
    acc_next       = acc;
    bad_next       = bad;
    rsp_valid_next = rsp_valid;
    rsp_div_next   = rsp_div;
    rsp_mul_next   = rsp_mul;
    rsp_bad_next   = rsp_bad;
    alu_a          = '0;
    alu_b          = '0;
    alu_sub        = 1'b1;

    if (rsp_valid && rsp.ready) begin
      rsp_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          a_hold_next = req.first_value;
          b_hold_next = req.second_value;
          x_next      = req.first_value;
          y_next      = req.second_value;
          k_next      = '0;
          if (req.first_value == '0 || req.second_value == '0) begin
            bad_next   = 1'b1;
            g_next     = '0;
            acc_next   = '0;
            state_next = ST_FINISH;
          end else begin
            bad_next   = 1'b0;
            state_next = ST_GCD;
          end
        end
      end

      ST_GCD: begin
        alu_a = alu_word_t'(x);
        alu_b = alu_word_t'(y);
        if (!x[0] && !y[0]) begin
          x_next = x >> 1;
          y_next = y >> 1;
          k_next = k + shift_t'(1);
        end else if (!x[0]) begin
          x_next = x >> 1;
        end else if (!y[0]) begin
          y_next = y >> 1;
        end else if (alu_res == '0) begin
          g_next     = operand_t'(x << k);
          rem_next   = '0;
          q_next     = a_hold;
          cnt_next   = shift_t'(OPERAND_BITS - 1);
          state_next = ST_DIV;
        end else if (borrow) begin
          // keep the larger odd value in x
          x_next = y;
          y_next = x;
        end else begin
          x_next = alu_res[OPERAND_BITS:1];
        end
      end

      ST_DIV: begin
        alu_a  = alu_word_t'({rem, q[OPERAND_BITS-1]});
        alu_b  = alu_word_t'(g);
        q_next = {q[OPERAND_BITS-2:0], ~borrow};
        if (borrow) begin
          rem_next = {rem[OPERAND_BITS-2:0], q[OPERAND_BITS-1]};
        end else begin
          rem_next = alu_res[OPERAND_BITS-1:0];
        end
        if (cnt == '0) begin
          acc_next   = '0;
          cnt_next   = shift_t'(OPERAND_BITS - 1);
          state_next = ST_MUL;
        end else begin
          cnt_next = cnt - shift_t'(1);
        end
      end

      ST_MUL: begin
        alu_sub  = 1'b0;
        alu_a    = alu_word_t'({acc[PRODUCT_BITS-2:0], 1'b0});
        alu_b    = q[OPERAND_BITS-1] ? alu_word_t'(b_hold) : '0;
        acc_next = alu_res[PRODUCT_BITS-1:0];
        q_next   = {q[OPERAND_BITS-2:0], 1'b0};
        if (cnt == '0) begin
          state_next = ST_FINISH;
        end else begin
          cnt_next = cnt - shift_t'(1);
        end
      end

      ST_FINISH: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_valid_next = 1'b1;
          rsp_div_next   = g;
          rsp_mul_next   = acc;
          rsp_bad_next   = bad;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    x       <= x_next;
    y       <= y_next;
    k       <= k_next;
    cnt     <= cnt_next;
    a_hold  <= a_hold_next;
    b_hold  <= b_hold_next;
    g       <= g_next;
    rem     <= rem_next;
    q       <= q_next;
    acc     <= acc_next;
    bad     <= bad_next;
    rsp_div <= rsp_div_next;
    rsp_mul <= rsp_mul_next;
    rsp_bad <= rsp_bad_next;
  end

endmodule

FILE: hdl/gcl_checker.sv
`timescale 1ns / 1ps
// port-level checks for the gcd / lcm unit, bound to gcd_lcm_unit_top
// depends on gcl_pkg

module gcl_checker
  import gcl_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_ready,
  input logic     rsp_valid,
  input logic     rsp_ready,
  input operand_t rsp_divisor,
  input product_t rsp_multiple,
  input logic     rsp_bad_input
);

  // response held until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped before it was taken");

  // busy right after a request transaction
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while a transaction is in progress");

  // rejected input returns zeros
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_bad_input |-> rsp_divisor == '0 && rsp_multiple == '0)
    else $error("rejected input with nonzero result");

  // valid input gives a nonzero divisor not above the multiple
  a_good_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_bad_input |->
      rsp_divisor != '0 && product_t'(rsp_divisor) <= rsp_multiple)
    else $error("divisor zero or above multiple");

endmodule

bind gcd_lcm_unit_top gcl_checker u_gcl_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_divisor   (rsp.divisor),
  .rsp_multiple  (rsp.multiple),
  .rsp_bad_input (rsp.bad_input)
);

FILE: verif/tb.sv
`timescale 1ns / 1ps
// testbench for gcd_lcm_unit_top: directed and random operand pairs,
// checked against a gcd/lcm predictor
// depends on gcl_pkg, gcl_req_if, gcl_rsp_if and the gcd_lcm_unit_top rtl

module tb;
  import gcl_pkg::*;

  localparam int unsigned OPERAND_MAX = (1 << OPERAND_BITS) - 1;
  localparam int          STALL_LIMIT = 4000;
  localparam int          TAIL_CYCLES = 200;
  localparam int          PRINT_LIMIT = 50;

  typedef struct packed {
    operand_t divisor;
    product_t multiple;
    logic     bad_input;
  } gcd_lcm_result_t;

  typedef struct packed {
    operand_t        first;
    operand_t        second;
    gcd_lcm_result_t result;
  } pending_pair_t;

  logic clk;
  logic rst;
  bit   no_idle;
  int   error_count;

  pending_pair_t pending_results[$];

  gcl_req_if req ();
  gcl_rsp_if rsp ();

  gcd_lcm_unit_top dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic gcd_lcm_result_t gcd_lcm_of(operand_t a, operand_t b);
    gcd_lcm_result_t r;
    operand_t        x;
    operand_t        y;
    operand_t        t;
    r = '0;
    if (a == '0 || b == '0) begin
      r.bad_input = 1'b1;
      return r;
    end
    x = a;
    y = b;
    while (y != '0) begin
      t = x % y;
      x = y;
      y = t;
    end
    r.divisor  = x;
    r.multiple = product_t'(a / x) * product_t'(b);
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int unsigned roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic operand_t random_operand();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return '0;
    if (roll < 45) return operand_t'($urandom);
    if (roll < 68) return operand_t'($urandom_range(1, 255));
    if (roll < 78) return operand_t'(1) << $urandom_range(0, OPERAND_BITS - 1);
    if (roll < 88) return operand_t'(OPERAND_MAX - $urandom_range(0, 600));
    return operand_t'($urandom_range(1, 4095));
  endfunction

  task automatic flag_mismatch(string msg);
    if (error_count < PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // valid stays high after acceptance; it is lowered only for a gap before the next pair or by wait_drained
  task automatic send_operands(operand_t a, operand_t b);
    int            gap;
    pending_pair_t entry;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.first_value  <= a;
    req.second_value <= b;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    entry.first  = a;
    entry.second = b;
    entry.result = gcd_lcm_of(a, b);
    pending_results.push_back(entry);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_corners();
    send_operands(operand_t'(1), operand_t'(1));
    send_operands(operand_t'(OPERAND_MAX), operand_t'(OPERAND_MAX));
    send_operands(operand_t'(1), operand_t'(OPERAND_MAX));
    send_operands(operand_t'(OPERAND_MAX), operand_t'(1));
    send_operands(operand_t'(OPERAND_MAX), operand_t'(OPERAND_MAX - 1));
    send_operands(operand_t'(65521), operand_t'(65519));
    send_operands(operand_t'(32768), operand_t'(16384));
    send_operands(operand_t'(32768), operand_t'(OPERAND_MAX));
    send_operands(operand_t'(12345), operand_t'(12345));
    send_operands(operand_t'(48), operand_t'(18));
    send_operands(operand_t'(18), operand_t'(48));
    send_operands(16'hAAAA, 16'h5555);
    send_operands(16'h5555, 16'hAAAA);
    send_operands(16'hFF00, 16'h00FF);
    send_operands(operand_t'(4096), operand_t'(6144));
    send_operands('0, '0);
    send_operands('0, operand_t'(1));
    send_operands(operand_t'(1), '0);
    send_operands('0, operand_t'(OPERAND_MAX));
    send_operands(operand_t'(OPERAND_MAX), '0);
    send_operands(operand_t'(7), operand_t'(7));
    wait_drained();
  endtask

  task automatic test_random_operands(int count);
    operand_t a;
    for (int i = 0; i < count; i++) begin
      a = random_operand();
      if ($urandom_range(0, 19) == 0) send_operands(a, a);
      else send_operands(a, random_operand());
    end
  endtask

  // pairs with a common factor of at least 2 so the divisor is never 1
  task automatic test_shared_factors(int count);
    int unsigned g;
    int unsigned x;
    int unsigned y;
    for (int i = 0; i < count; i++) begin
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 8000) : $urandom_range(2, 255);
      x = $urandom_range(1, OPERAND_MAX / g);
      y = $urandom_range(1, OPERAND_MAX / g);
      send_operands(operand_t'(g * x), operand_t'(g * y));
    end
  endtask

  task automatic test_back_to_back(int count);
    no_idle = 1'b1;
    test_random_operands(count);
    no_idle = 1'b0;
  endtask

  task automatic test_pause_until_drained(int rounds);
    for (int i = 0; i < rounds; i++) begin
      test_random_operands($urandom_range(1, 6));
      wait_drained();
    end
  endtask

  initial begin : rsp_ready_driver
    int stall;
    int hold;
    rsp.ready = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      hold = $urandom_range(1, 8);
      repeat (hold) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    pending_pair_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result with no transaction pending: gcd=%0d lcm=%0d bad=%0b",
                                rsp.divisor, rsp.multiple, rsp.bad_input));
      end else begin
        want = pending_results.pop_front();
        if (rsp.divisor !== want.result.divisor)
          flag_mismatch($sformatf("(%0d, %0d) divisor %0d, expected %0d", want.first,
                                  want.second, rsp.divisor, want.result.divisor));
        if (rsp.multiple !== want.result.multiple)
          flag_mismatch($sformatf("(%0d, %0d) multiple %0d, expected %0d", want.first,
                                  want.second, rsp.multiple, want.result.multiple));
        if (rsp.bad_input !== want.result.bad_input)
          flag_mismatch($sformatf("(%0d, %0d) bad_input %0b, expected %0b", want.first,
                                  want.second, rsp.bad_input, want.result.bad_input));
      end
    end
  end

  // cycles with no transaction on either channel
  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles, %0d results pending",
                 quiet_cycles, pending_results.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst              = 1'b1;
    req.valid        = 1'b0;
    req.first_value  = '0;
    req.second_value = '0;
    no_idle          = 1'b0;
    error_count      = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_directed_corners();
    test_random_operands(650);
    wait_drained();
    test_shared_factors(200);
    test_back_to_back(180);
    test_pause_until_drained(5);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
